// File: sv/pvoc_pkg.sv
package pvoc_pkg;

    // Sizing of the vertex store and the coordinate datapath.
    localparam int MAX_VERTS  = 16;
    localparam int COORD_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_VERTS);
    localparam int CNT_W      = $clog2(MAX_VERTS + 1);
    localparam int PROD_W     = 2 * COORD_BITS;
    localparam int PID_W      = 24;
    localparam int MODE_W     = 2;

    typedef logic [MODE_W-1:0] t_mode;

    // Mode register codes; the two unused codes behave as polygon mode.
    localparam t_mode MODE_1D = t_mode'(1);
    localparam t_mode MODE_2D = t_mode'(2);

    // Which store entry a read command fetches.
    typedef enum logic [2:0] {
        RS_MAX,
        RS_SUCC,
        RS_PRED,
        RS_FIRST,
        RS_SECOND,
        RS_EMIT
    } t_rsel;

    // One vertex as it arrives.
    typedef struct packed {
        logic [PID_W-1:0]  point_index;
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic              last_vertex;
    } t_in;

    // One result of a cell.
    typedef struct packed {
        logic [PID_W-1:0] out_index;
        logic             out_last;
        logic             was_reversed;
        logic             count_error;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             accept;
        logic             rd_en;
        t_rsel            rd_sel;
        logic             cap_m;
        logic             cap_s;
        logic             diff_en;
        logic             mul_en;
        logic             mul_sel;
        logic             sgn_first;
        logic             sgn_second;
        logic             cmp_2d;
        logic             cmp_1d;
        logic             emit;
        logic             emit_last;
        logic             err_out;
        logic             clr;
        logic [IDX_W-1:0] emit_k;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             mode_one;
    } t_stat;

endpackage

// File: sv/pvoc_ctrl.sv
module pvoc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_last,
    input  pvoc_pkg::t_stat i_stat,
    output logic            o_busy,
    output pvoc_pkg::t_cmd  o_cmd
);
    import pvoc_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DECIDE,
        S_RD_M,
        S_RD_S,
        S_RD_P,
        S_DIFF,
        S_MUL1,
        S_MUL2,
        S_CONV,
        S_CMP,
        S_RD_A,
        S_RD_B,
        S_CAP_B,
        S_CMP1,
        S_EMIT,
        S_ERR
    } t_state;

    t_state           r_state;
    logic             r_busy;
    logic             r_is_1d;
    logic [IDX_W-1:0] r_k;
    logic             w_accept;
    logic             w_k_last;

    assign w_accept = i_start & ~r_busy;
    assign w_k_last = (CNT_W'(r_k) + CNT_W'(1)) == i_stat.count;
    assign o_busy   = r_busy;

    // State, busy flag, sampled mode and emission counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_busy  <= 1'b0;
            r_is_1d <= 1'b0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept && i_last) begin
                        r_is_1d <= i_stat.mode_one;
                        r_busy  <= 1'b1;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_is_1d) begin
                        if (i_stat.count != CNT_W'(2)) begin
                            r_state <= S_ERR;
                        end else begin
                            r_state <= S_RD_A;
                        end
                    end else begin
                        r_state <= S_RD_M;
                    end
                end
                S_RD_M:  r_state <= S_RD_S;
                S_RD_S:  r_state <= S_RD_P;
                S_RD_P:  r_state <= S_DIFF;
                S_DIFF:  r_state <= S_MUL1;
                S_MUL1:  r_state <= S_MUL2;
                S_MUL2:  r_state <= S_CONV;
                S_CONV:  r_state <= S_CMP;
                S_CMP:   r_state <= S_EMIT;
                S_RD_A:  r_state <= S_RD_B;
                S_RD_B:  r_state <= S_CAP_B;
                S_CAP_B: r_state <= S_CMP1;
                S_CMP1:  r_state <= S_EMIT;
                S_EMIT: begin
                    if (w_k_last) begin
                        r_k     <= '0;
                        r_busy  <= 1'b0;
                        r_state <= S_LOAD;
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_ERR: begin
                    r_busy  <= 1'b0;
                    r_state <= S_LOAD;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    // Command decode for the datapath.
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_sel = RS_MAX;
        o_cmd.accept = w_accept;
        o_cmd.emit_k = r_k;
        unique case (r_state)
            S_RD_M: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_MAX;
            end
            S_RD_S: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_SUCC;
                o_cmd.cap_m  = 1'b1;
            end
            S_RD_P: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_PRED;
                o_cmd.cap_s  = 1'b1;
            end
            S_DIFF: o_cmd.diff_en = 1'b1;
            S_MUL1: o_cmd.mul_en = 1'b1;
            S_MUL2: begin
                o_cmd.mul_en    = 1'b1;
                o_cmd.mul_sel   = 1'b1;
                o_cmd.sgn_first = 1'b1;
            end
            S_CONV: o_cmd.sgn_second = 1'b1;
            S_CMP:  o_cmd.cmp_2d = 1'b1;
            S_RD_A: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_FIRST;
            end
            S_RD_B: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RS_SECOND;
                o_cmd.cap_m  = 1'b1;
            end
            S_CAP_B: o_cmd.cap_s = 1'b1;
            S_CMP1:  o_cmd.cmp_1d = 1'b1;
            S_EMIT: begin
                o_cmd.rd_en     = 1'b1;
                o_cmd.rd_sel    = RS_EMIT;
                o_cmd.emit      = 1'b1;
                o_cmd.emit_last = w_k_last;
                o_cmd.clr       = w_k_last;
            end
            S_ERR: begin
                o_cmd.err_out = 1'b1;
                o_cmd.clr     = 1'b1;
            end
            default: o_cmd.accept = w_accept;
        endcase
    end

endmodule

// File: sv/pvoc_dp.sv
module pvoc_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pvoc_pkg::t_cmd             i_cmd,
    input  pvoc_pkg::t_in              i_item,
    input  logic                       i_cfg_we,
    input  logic [pvoc_pkg::MODE_W-1:0] i_cfg_data,
    output pvoc_pkg::t_stat            o_stat,
    output logic                       o_valid,
    output pvoc_pkg::t_out             o_result
);
    import pvoc_pkg::*;

    // Magnitude of a coordinate difference; it always fits COORD_BITS bits.
    function automatic logic [COORD_BITS-1:0] mag_of(input logic [COORD_BITS:0] d);
        logic [COORD_BITS:0] t;
        t = d[COORD_BITS] ? (~d + (COORD_BITS+1)'(1)) : d;
        return t[COORD_BITS-1:0];
    endfunction

    // Vertex store.
    logic [PID_W-1:0]      mem_idx [MAX_VERTS];
    logic [COORD_BITS-1:0] mem_x   [MAX_VERTS];
    logic [COORD_BITS-1:0] mem_y   [MAX_VERTS];

    t_mode                   r_mode;
    logic [CNT_W-1:0]        r_count;
    logic [IDX_W-1:0]        r_max_pos;
    logic signed [COORD_BITS-1:0] r_max_x;

    logic [PID_W-1:0]        r_rd_idx;
    logic signed [COORD_BITS-1:0] r_rd_x;
    logic signed [COORD_BITS-1:0] r_rd_y;
    logic signed [COORD_BITS-1:0] r_xm;
    logic signed [COORD_BITS-1:0] r_ym;
    logic signed [COORD_BITS-1:0] r_xs;
    logic signed [COORD_BITS-1:0] r_ys;

    logic [COORD_BITS-1:0]   r_ma0;
    logic [COORD_BITS-1:0]   r_mb0;
    logic [COORD_BITS-1:0]   r_ma1;
    logic [COORD_BITS-1:0]   r_mb1;
    logic                    r_neg0;
    logic                    r_neg1;
    logic [PROD_W-1:0]       r_mag;
    logic                    r_neg;
    logic signed [PROD_W:0]  r_p1;
    logic signed [PROD_W:0]  r_p2;
    logic                    r_rev;

    logic                    r_valid;
    logic                    r_o_last;
    logic                    r_o_rev;
    logic                    r_o_err;

    logic signed [COORD_BITS-1:0] w_x;
    logic signed [COORD_BITS-1:0] w_y;
    logic                    w_room;
    logic [IDX_W-1:0]        w_wr_addr;
    logic [IDX_W-1:0]        w_succ;
    logic [IDX_W-1:0]        w_pred;
    logic [IDX_W-1:0]        w_emit_addr;
    logic [IDX_W-1:0]        w_rd_addr;
    logic [COORD_BITS:0]     w_dxs;
    logic [COORD_BITS:0]     w_dyp;
    logic [COORD_BITS:0]     w_dys;
    logic [COORD_BITS:0]     w_dxp;
    logic signed [PROD_W:0]  w_sprod;

    assign w_x       = i_item.x_coord[COORD_BITS-1:0];
    assign w_y       = i_item.y_coord[COORD_BITS-1:0];
    assign w_room    = r_count < CNT_W'(MAX_VERTS);
    assign w_wr_addr = r_count[IDX_W-1:0];

    // Cyclic neighbors of the pivot vertex and the emission address.
    assign w_succ = ((CNT_W'(r_max_pos) + CNT_W'(1)) >= r_count) ? '0
                    : r_max_pos + IDX_W'(1);
    assign w_pred = (r_max_pos == '0) ? IDX_W'(r_count - CNT_W'(1))
                    : r_max_pos - IDX_W'(1);
    assign w_emit_addr = r_rev ? IDX_W'(r_count - CNT_W'(1) - CNT_W'(i_cmd.emit_k))
                         : i_cmd.emit_k;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RS_MAX:    w_rd_addr = r_max_pos;
            RS_SUCC:   w_rd_addr = w_succ;
            RS_PRED:   w_rd_addr = w_pred;
            RS_FIRST:  w_rd_addr = '0;
            RS_SECOND: w_rd_addr = IDX_W'(1);
            RS_EMIT:   w_rd_addr = w_emit_addr;
            default:   w_rd_addr = '0;
        endcase
    end

    // Differences about the pivot; the predecessor comes straight from the read.
    assign w_dxs = {r_xs[COORD_BITS-1], r_xs} - {r_xm[COORD_BITS-1], r_xm};
    assign w_dys = {r_ys[COORD_BITS-1], r_ys} - {r_ym[COORD_BITS-1], r_ym};
    assign w_dxp = {r_rd_x[COORD_BITS-1], r_rd_x} - {r_xm[COORD_BITS-1], r_xm};
    assign w_dyp = {r_rd_y[COORD_BITS-1], r_rd_y} - {r_ym[COORD_BITS-1], r_ym};

    // Registered unsigned product turned back into a signed value.
    assign w_sprod = r_neg ? ((PROD_W+1)'(0) - $signed({1'b0, r_mag}))
                     : $signed({1'b0, r_mag});

    // Mode register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_2D;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // Store write on each accepted vertex while there is room.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_room) begin
            mem_idx[w_wr_addr] <= i_item.point_index;
            mem_x[w_wr_addr]   <= w_x;
            mem_y[w_wr_addr]   <= w_y;
        end
    end

    // Store read with registered data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_idx <= mem_idx[w_rd_addr];
            r_rd_x   <= mem_x[w_rd_addr];
            r_rd_y   <= mem_y[w_rd_addr];
        end else if (i_cmd.err_out) begin
            r_rd_idx <= '0;
        end
    end

    // Vertex count and running maximum of x.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_max_pos <= '0;
            r_max_x   <= '0;
        end else if (i_cmd.clr) begin
            r_count   <= '0;
            r_max_pos <= '0;
            r_max_x   <= '0;
        end else if (i_cmd.accept && w_room) begin
            r_count <= r_count + CNT_W'(1);
            if (r_count == '0 || w_x > r_max_x) begin
                r_max_pos <= w_wr_addr;
                r_max_x   <= w_x;
            end
        end
    end

    // Orientation arithmetic: capture, differences, product, compare.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_m) begin
            r_xm <= r_rd_x;
            r_ym <= r_rd_y;
        end
        if (i_cmd.cap_s) begin
            r_xs <= r_rd_x;
            r_ys <= r_rd_y;
        end
        if (i_cmd.diff_en) begin
            r_ma0  <= mag_of(w_dxs);
            r_mb0  <= mag_of(w_dyp);
            r_neg0 <= w_dxs[COORD_BITS] ^ w_dyp[COORD_BITS];
            r_ma1  <= mag_of(w_dys);
            r_mb1  <= mag_of(w_dxp);
            r_neg1 <= w_dys[COORD_BITS] ^ w_dxp[COORD_BITS];
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_sel) begin
                r_mag <= PROD_W'(r_ma1) * PROD_W'(r_mb1);
                r_neg <= r_neg1;
            end else begin
                r_mag <= PROD_W'(r_ma0) * PROD_W'(r_mb0);
                r_neg <= r_neg0;
            end
        end
        if (i_cmd.sgn_first) begin
            r_p1 <= w_sprod;
        end
        if (i_cmd.sgn_second) begin
            r_p2 <= w_sprod;
        end
        if (i_cmd.cmp_2d) begin
            r_rev <= r_p1 < r_p2;
        end else if (i_cmd.cmp_1d) begin
            r_rev <= r_xs < r_xm;
        end
    end

    // Result flags and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit | i_cmd.err_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_last <= i_cmd.emit_last;
            r_o_rev  <= r_rev;
            r_o_err  <= 1'b0;
        end else if (i_cmd.err_out) begin
            r_o_last <= 1'b1;
            r_o_rev  <= 1'b0;
            r_o_err  <= 1'b1;
        end
    end

    assign o_stat.count    = r_count;
    assign o_stat.mode_one = (r_mode == MODE_1D);

    assign o_valid               = r_valid;
    assign o_result.out_index    = r_rd_idx;
    assign o_result.out_last     = r_o_last;
    assign o_result.was_reversed = r_o_rev;
    assign o_result.count_error  = r_o_err;

endmodule

// File: sv/polygon_vertex_orient_clockwise.sv
// Puts the vertices of one mesh cell into clockwise order.
// Vertices arrive on i_item, one per transfer: a transfer happens at a clock
// edge with start high and busy low. The cell ends with a vertex whose
// last_vertex flag is set; vertices beyond the store depth are dropped.
// After the closing vertex busy stays high while the block works: in polygon
// mode it fetches the first vertex of greatest x and its two neighbors from
// the vertex store, one store read a cycle, and forms the cross product with
// one shared multiplier. Then one result a cycle is read out of the store.
// In 1D mode the two points are compared, then 2 results follow; a wrong
// count gives one error result instead, from the error state that follows
// the decide state. Results come out on o_result for exactly one cycle each,
// marked by o_valid, in the cycle after their store read; the receiver
// cannot stall them. busy drops in the cycle that the last result of the
// cell is shown. The mode register is written through i_cfg_we / i_cfg_data;
// the user must write it only while idle, as the block does not enforce it.
// Reset returns the block to the load state with an empty cell and mode 2.
module polygon_vertex_orient_clockwise (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  pvoc_pkg::t_in               i_item,
    input  logic                        i_cfg_we,
    input  logic [pvoc_pkg::MODE_W-1:0] i_cfg_data,
    output logic                        o_valid,
    output pvoc_pkg::t_out              o_result
);
    import pvoc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencing of load, orientation test and read-out.
    pvoc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_item.last_vertex),
        .i_stat  (w_stat),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    // Vertex store, pivot tracking and cross-product arithmetic.
    pvoc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_stat     (w_stat),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule
